FILE: sv/sfd_pkg.sv
// Shared constants for the SLIP frame decoder: byte codes, widths and defaults.
package sfd_pkg;

  // SLIP special byte codes
  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  // Field widths fixed by the interface
  localparam int DATA_W  = 8;
  localparam int INDEX_W = 6;
  localparam int LEN_W   = 7;
  localparam int CNT16_W = 16;

  // Defaults
  localparam int FRAME_DEPTH_DEF = 64;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

FILE: sv/sfd_frame_store.sv
// Frame store: single-port-write, single-port-read memory with registered read data.
module sfd_frame_store
  import sfd_pkg::*;
#(
  parameter int DEPTH = FRAME_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  byte_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output byte_t         rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/slip_frame_decoder.sv
// SLIP receive decoder top level: mode machine, counters, frame store and readout.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | input     | in_valid / in_stall | in_rx_byte
//  out_    | output    | out_valid/out_stall | data_byte, byte_index, frame_length,
//          |           |                     | last_byte, good/bad/overrun_frames
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_frame_limit
//
// Outside a readout one raw byte is taken every cycle; in_stall is high during a readout.
// A closing END starts a readout of the frame store: one memory read per cycle
// while the output does not stall, with in_stall high until the readout ends.
// Output stalls slow the readout through the single read port; a byte read from
// the store waits in its read register until the output register is free.
// Reset (rst_n low, synchronous) clears mode, counters and readout control and sets
// the limit to 64; the frame store is not cleared.
module slip_frame_decoder
  import sfd_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_data_byte,
  output logic [5:0]         out_byte_index,
  output logic [6:0]         out_frame_length,
  output logic               out_last_byte,
  output logic [15:0]        out_good_frames,
  output logic [15:0]        out_bad_frames,
  output logic [15:0]        out_overrun_frames,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_frame_limit
);

  localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  // decode modes
  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;

  // sequencer states
  localparam logic SEQ_RUN  = 1'b0;
  localparam logic SEQ_DUMP = 1'b1;

  logic [LEN_W-1:0]   limit_r;
  logic [1:0]         mode_r, mode_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CNT16_W-1:0] good_r, good_nxt;
  logic [CNT16_W-1:0] bad_r, bad_nxt;
  logic [CNT16_W-1:0] over_r, over_nxt;
  logic               seq_r, seq_nxt;
  logic [CW-1:0]      len_r, len_nxt;
  logic [CW-1:0]      rd_idx_r;
  logic [CW-1:0]      pend_idx_r;
  logic               pend_r;

  logic               in_acc;
  logic               wr_en;
  byte_t              wr_data;
  logic [LEN_W-1:0]   lim_eff;
  logic               rd_en;
  logic               xfer;
  byte_t              rd_data;

  // output register
  logic               out_valid_r;
  byte_t              out_data_r;
  logic [INDEX_W-1:0] out_idx_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_last_r;
  logic [CNT16_W-1:0] out_good_r, out_bad_r, out_over_r;

  assign in_stall  = (seq_r == SEQ_DUMP);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_frame_limit;
    end
  end

  // limit clipped to the store depth
  assign lim_eff = (limit_r > LEN_W'(FRAME_DEPTH)) ? LEN_W'(FRAME_DEPTH) : limit_r;

  // decode machine: next mode, counters and store writes
  always_comb begin
    logic       do_store;
    byte_t      sbyte;
    mode_nxt = mode_r;
    count_nxt = count_r;
    good_nxt = good_r;
    bad_nxt = bad_r;
    over_nxt = over_r;
    seq_nxt = seq_r;
    len_nxt = len_r;
    wr_en = 1'b0;
    wr_data = in_rx_byte;
    do_store = 1'b0;
    sbyte = in_rx_byte;
    if (in_acc) begin
      unique case (mode_r)
        MODE_WAIT: begin
          if (in_rx_byte == CODE_END) begin
            mode_nxt = MODE_RECV;
            count_nxt = '0;
          end
        end
        MODE_RECV: begin
          if (in_rx_byte == CODE_ESC) begin
            mode_nxt = MODE_ESC;
          end else if (in_rx_byte == CODE_END) begin
            // non-empty frame closes; empty one is ignored
            if (count_r != '0) begin
              mode_nxt = MODE_WAIT;
              good_nxt = good_r + 1'b1;
              len_nxt = count_r;
              seq_nxt = SEQ_DUMP;
            end
          end else begin
            do_store = 1'b1;
          end
        end
        MODE_ESC: begin
          if (in_rx_byte == CODE_ESC_END) begin
            do_store = 1'b1;
            sbyte = CODE_END;
          end else if (in_rx_byte == CODE_ESC_ESC) begin
            do_store = 1'b1;
            sbyte = CODE_ESC;
          end else begin
            mode_nxt = MODE_WAIT;
            bad_nxt = bad_r + 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_WAIT;
          bad_nxt = bad_r + 1'b1;
        end
      endcase
      // payload byte: store or overrun
      if (do_store) begin
        if (LEN_W'(count_r) >= lim_eff) begin
          mode_nxt = MODE_WAIT;
          bad_nxt = bad_r + 1'b1;
          over_nxt = over_r + 1'b1;
        end else begin
          wr_en = 1'b1;
          wr_data = sbyte;
          count_nxt = count_r + 1'b1;
          mode_nxt = MODE_RECV;
        end
      end
    end
    // readout finished
    if (seq_r == SEQ_DUMP && rd_idx_r == len_r && !pend_r) begin
      seq_nxt = SEQ_RUN;
    end
  end

  // readout: pending read data moves to the output register when it is free
  assign xfer  = pend_r && (!out_valid_r || !out_stall);
  assign rd_en = (seq_r == SEQ_DUMP) && (rd_idx_r != len_r) && (!pend_r || xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      count_r <= '0;
      good_r <= '0;
      bad_r <= '0;
      over_r <= '0;
      seq_r <= SEQ_RUN;
      len_r <= '0;
      rd_idx_r <= '0;
      pend_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      count_r <= count_nxt;
      good_r <= good_nxt;
      bad_r <= bad_nxt;
      over_r <= over_nxt;
      seq_r <= seq_nxt;
      len_r <= len_nxt;
      if (seq_r == SEQ_RUN) begin
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (rd_en) begin
        pend_r <= 1'b1;
      end else if (xfer) begin
        pend_r <= 1'b0;
      end
    end
  end

  // index of the byte in flight from the store
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx_r <= rd_idx_r;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload; counters are steady during readout
  always_ff @(posedge clk) begin
    if (xfer) begin
      out_data_r <= rd_data;
      out_idx_r <= INDEX_W'(pend_idx_r);
      out_len_r <= LEN_W'(len_r);
      out_last_r <= (CW'(pend_idx_r + 1'b1) == len_r);
      out_good_r <= good_r;
      out_bad_r <= bad_r;
      out_over_r <= over_r;
    end
  end

  sfd_frame_store #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_data_r;
  assign out_byte_index     = out_idx_r;
  assign out_frame_length   = out_len_r;
  assign out_last_byte      = out_last_r;
  assign out_good_frames    = out_good_r;
  assign out_bad_frames     = out_bad_r;
  assign out_overrun_frames = out_over_r;

`ifndef SYNTHESIS
  // a read in flight only exists during readout
  a_pend_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (seq_r == SEQ_DUMP))
    else $error("store read pending outside readout");

  // the read index never passes the frame length
  a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_DUMP) |-> (rd_idx_r <= len_r))
    else $error("readout index beyond frame length");

  // the marked byte is the final position of the frame
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> ((LEN_W'(out_idx_r) + 1'b1) == out_len_r))
    else $error("last byte flag on wrong position");

  // frame store never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(FRAME_DEPTH))
    else $error("byte count beyond store depth");
`endif

endmodule
